### rtl/vfcc_pkg.sv
// Shared types and codes for the vector field circular convolution block.
package vfcc_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_KERNEL = 2'd0,
        OP_LOAD_SOURCE = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_FIELD_X  = 3'd0;
    localparam logic [2:0] REG_FIELD_Y  = 3'd1;
    localparam logic [2:0] REG_FIELD_Z  = 3'd2;
    localparam logic [2:0] REG_EXTENT_X = 3'd3;
    localparam logic [2:0] REG_EXTENT_Y = 3'd4;
    localparam logic [2:0] REG_EXTENT_Z = 3'd5;

    localparam int POS_BITS = 5;
    localparam int FS_BITS  = 5;
    localparam int EX_BITS  = 6;
    localparam int ACC_BITS = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

### rtl/vfcc_mac.sv
// Three-lane multiply-accumulate stage: register the products, then add them to the sum.
module vfcc_mac
    import vfcc_pkg::*;
#(
    parameter int COMP_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       en,
    input  logic [3*COMP_BITS-1:0]     kvec,
    input  logic [3*COMP_BITS-1:0]     svec,
    output logic signed [ACC_BITS-1:0] sum
);
    localparam int PB = 2 * COMP_BITS;

    logic signed [PB-1:0]       prod_reg [3];
    logic                       pv_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] add_next;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= $signed(kvec[i*COMP_BITS +: COMP_BITS])
                         * $signed(svec[i*COMP_BITS +: COMP_BITS]);
        end
    end

    always_comb
    begin
        add_next = acc_reg;
        for (int i = 0; i < 3; i++)
        begin
            add_next = add_next + ACC_BITS'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg <= en;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= add_next;
            end
        end
    end

    assign sum = acc_reg;
endmodule

### rtl/vector_field_circular_convolution.sv
// Top level: kernel and source stores, address walk over the field, result strobe.
//
//  channel | signals                                  | transfer
//  input   | start, busy, opcode, pos_*, comp_*       | start && !busy
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//  result  | done, potential, at_*                    | done (one cycle)
//
// A compute walks all fx*fy*fz source cells, then drains through memory read,
// product and accumulate, with one read port per store and one MAC. Reset
// returns the control, config and accumulator registers to their reset
// values and leaves the stores unwritten. The receiver cannot stall.
module vector_field_circular_convolution
    import vfcc_pkg::*;
#(
    parameter int MAX_FIELD  = 16,
    parameter int MAX_EXTENT = 32,
    parameter int COMP_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [4:0]                 pos_x,
    input  logic [4:0]                 pos_y,
    input  logic [4:0]                 pos_z,
    input  logic signed [15:0]         comp_x,
    input  logic signed [15:0]         comp_y,
    input  logic signed [15:0]         comp_z,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [5:0]                 cfg_data,
    output logic                       done,
    output logic signed [47:0]         potential,
    output logic [3:0]                 at_x,
    output logic [3:0]                 at_y,
    output logic [3:0]                 at_z
);
    localparam int FB = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
    localparam int EB = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
    localparam int KD = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
    localparam int SD = MAX_FIELD * MAX_FIELD * MAX_FIELD;
    localparam int VB = 3 * COMP_BITS;
    localparam int CB = 8;

    logic [VB-1:0] kmem [KD];
    logic [VB-1:0] smem [SD];

    logic [FS_BITS-1:0] fsz_reg [3];
    logic [EX_BITS-1:0] ext_reg [3];

    state_t state_reg, state_next;
    logic [CB-1:0] m_reg [3];
    logic [CB-1:0] fs_reg [3];
    logic [CB-1:0] ex_reg [3];
    logic [CB-1:0] p_reg [3];
    logic [2:0]    drain_reg;
    logic          rd_reg;

    logic [CB-1:0] pin [3];
    logic [CB-1:0] fs_eff [3];
    logic [CB-1:0] ex_eff [3];
    logic [CB-1:0] kc [3];
    logic          in_field;
    logic          accept;
    logic          last;
    logic [VB-1:0] kq_reg, sq_reg;
    logic          mac_clear, mac_en;
    logic signed [ACC_BITS-1:0] sum;
    logic [VB-1:0] vin;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign pin[0] = CB'(pos_x);
    assign pin[1] = CB'(pos_y);
    assign pin[2] = CB'(pos_z);
    assign vin = {COMP_BITS'(comp_z), COMP_BITS'(comp_y), COMP_BITS'(comp_x)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fsz_reg[i] <= FS_BITS'(16);
                ext_reg[i] <= EX_BITS'(32);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIELD_X:  fsz_reg[0] <= cfg_data[4:0];
                REG_FIELD_Y:  fsz_reg[1] <= cfg_data[4:0];
                REG_FIELD_Z:  fsz_reg[2] <= cfg_data[4:0];
                REG_EXTENT_X: ext_reg[0] <= cfg_data;
                REG_EXTENT_Y: ext_reg[1] <= cfg_data;
                REG_EXTENT_Z: ext_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the registers to 1..max, cap each field size by its extent, and check the position against the field.
    always_comb
    begin
        in_field = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            ex_eff[i] = (ext_reg[i] == '0) ? CB'(1)
                      : ((CB'(ext_reg[i]) > CB'(MAX_EXTENT)) ? CB'(MAX_EXTENT)
                      : CB'(ext_reg[i]));
            fs_eff[i] = (fsz_reg[i] == '0) ? CB'(1)
                      : ((CB'(fsz_reg[i]) > CB'(MAX_FIELD)) ? CB'(MAX_FIELD)
                      : CB'(fsz_reg[i]));
            if (fs_eff[i] > ex_eff[i])
            begin
                fs_eff[i] = ex_eff[i];
            end
            if (pin[i] >= fs_eff[i])
            begin
                in_field = 1'b0;
            end
        end
    end

    // Loads write straight into the stores; out-of-range positions are dropped.
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD_KERNEL && pin[0] < CB'(MAX_EXTENT)
            && pin[1] < CB'(MAX_EXTENT) && pin[2] < CB'(MAX_EXTENT))
        begin
            kmem[{pin[2][EB-1:0], pin[1][EB-1:0], pin[0][EB-1:0]}] <= vin;
        end
        if (accept && opcode == OP_LOAD_SOURCE && pin[0] < CB'(MAX_FIELD)
            && pin[1] < CB'(MAX_FIELD) && pin[2] < CB'(MAX_FIELD))
        begin
            smem[{pin[2][FB-1:0], pin[1][FB-1:0], pin[0][FB-1:0]}] <= vin;
        end
    end

    // Wrapped kernel coordinate: p + E - m, one subtraction of E.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kc[i] = p_reg[i] + ex_reg[i] - m_reg[i];
            if (kc[i] >= ex_reg[i])
            begin
                kc[i] = kc[i] - ex_reg[i];
            end
        end
    end

    assign last = (m_reg[0] == fs_reg[0] - 1'b1) && (m_reg[1] == fs_reg[1] - 1'b1)
               && (m_reg[2] == fs_reg[2] - 1'b1);

    always_ff @(posedge clk)
    begin
        kq_reg <= kmem[{kc[2][EB-1:0], kc[1][EB-1:0], kc[0][EB-1:0]}];
        sq_reg <= smem[{m_reg[2][FB-1:0], m_reg[1][FB-1:0], m_reg[0][FB-1:0]}];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && opcode == OP_COMPUTE && in_field) state_next = ST_RUN;
            ST_RUN:   if (last) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 3'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        mac_clear = (state_reg == ST_IDLE);
        done      = (state_reg == ST_DRAIN) && (drain_reg == 3'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            rd_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rd_reg    <= (state_reg == ST_RUN);
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 3'd1 : 3'd0;
            if (state_reg == ST_IDLE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= '0;
                end
            end
            else if (state_reg == ST_RUN)
            begin
                // Advance x fastest, then y, then z.
                if (m_reg[0] != fs_reg[0] - 1'b1)
                begin
                    m_reg[0] <= m_reg[0] + 1'b1;
                end
                else
                begin
                    m_reg[0] <= '0;
                    if (m_reg[1] != fs_reg[1] - 1'b1)
                    begin
                        m_reg[1] <= m_reg[1] + 1'b1;
                    end
                    else
                    begin
                        m_reg[1] <= '0;
                        m_reg[2] <= m_reg[2] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]  <= pin[i];
                fs_reg[i] <= fs_eff[i];
                ex_reg[i] <= ex_eff[i];
            end
        end
    end

    assign mac_en = rd_reg;

    vfcc_mac #(.COMP_BITS(COMP_BITS)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mac_clear),
        .en    (mac_en),
        .kvec  (kq_reg),
        .svec  (sq_reg),
        .sum   (sum)
    );

    assign potential = sum;
    assign at_x = p_reg[0][3:0];
    assign at_y = p_reg[1][3:0];
    assign at_z = p_reg[2][3:0];

`ifndef NO_ASSERTIONS
    a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_DRAIN) else $error("done outside drain");
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> busy) else $error("running while not busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("block not idle after result");
`endif
endmodule
